>>> hw/rtl/raid5_sector_to_disk_mapper_macros.svh
// assertion helpers for the sector mapper
`ifndef RAID5_SECTOR_TO_DISK_MAPPER_MACROS_SVH
`define RAID5_SECTOR_TO_DISK_MAPPER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define R5M_ASSERT_IMPL(lbl, clkx, rstx, a, b) \
    lbl: assert property (@(posedge clkx) disable iff (!rstx) (a) |-> (b)) \
        else $error("r5m assertion failed");

// two signals agree at every edge
`define R5M_ASSERT_EQ(lbl, clkx, rstx, a, b) \
    lbl: assert property (@(posedge clkx) disable iff (!rstx) ((a) == (b))) \
        else $error("r5m signals disagree");

`endif

>>> hw/rtl/r5m_pkg.sv
package r5m_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_COLUMNS  = 32;
    localparam int DEF_ADDRESS_BITS = 48;

    // configuration port
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    // register indexes
    localparam cfg_index_t REG_NUM_COLUMNS      = 2'd0;
    localparam cfg_index_t REG_SECTORS_PER_UNIT = 2'd1;

    // reset values
    localparam logic [5:0]  RST_NUM_COLUMNS      = 6'd3;
    localparam logic [15:0] RST_SECTORS_PER_UNIT = 16'd32;

    // beat control handed between cells
    typedef struct packed {
        logic vld;
    } beat_ctl_t;

endpackage

>>> hw/rtl/r5m_div_cell.sv
module r5m_div_cell #(
    parameter int W  = 48,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  r5m_pkg::beat_ctl_t  ctl_in,
    input  logic [DW-1:0]       rem_in,
    input  logic [W-1:0]        work_in,
    input  logic [SW-1:0]       side_in,
    input  logic [DW-1:0]       divisor,
    output r5m_pkg::beat_ctl_t  ctl_out,
    output logic [DW-1:0]       rem_out,
    output logic [W-1:0]        work_out,
    output logic [SW-1:0]       side_out
);
    import r5m_pkg::*;

    beat_ctl_t     ctl_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [W-1:0]  work_reg, work_next;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_in, work_in[W-1]};
        diff      = trial - {1'b0, divisor};
        take      = (trial >= {1'b0, divisor});
        rem_next  = take ? diff[DW-1:0] : trial[DW-1:0];
        work_next = {work_in[W-2:0], take};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        side_reg <= side_in;
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign work_out = work_reg;
    assign side_out = side_reg;

endmodule

>>> hw/rtl/r5m_div_chain.sv
module r5m_div_chain #(
    parameter int W  = 48,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  r5m_pkg::beat_ctl_t  ctl_in,
    input  logic [W-1:0]        dividend,
    input  logic [SW-1:0]       side_in,
    input  logic [DW-1:0]       divisor,
    output r5m_pkg::beat_ctl_t  ctl_out,
    output logic [W-1:0]        quotient,
    output logic [DW-1:0]       remainder,
    output logic [SW-1:0]       side_out
);
    import r5m_pkg::*;

    beat_ctl_t     ctl_c  [W+1];
    logic [DW-1:0] rem_c  [W+1];
    logic [W-1:0]  work_c [W+1];
    logic [SW-1:0] side_c [W+1];

    // head of the row
    assign ctl_c[0]  = ctl_in;
    assign rem_c[0]  = '0;
    assign work_c[0] = dividend;
    assign side_c[0] = side_in;

    // one quotient bit per cell, most significant first
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        r5m_div_cell #(.W(W), .DW(DW), .SW(SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl_c[i]),
            .rem_in   (rem_c[i]),
            .work_in  (work_c[i]),
            .side_in  (side_c[i]),
            .divisor  (divisor),
            .ctl_out  (ctl_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .work_out (work_c[i+1]),
            .side_out (side_c[i+1])
        );
    end

    assign ctl_out   = ctl_c[W];
    assign quotient  = work_c[W];
    assign remainder = rem_c[W];
    assign side_out  = side_c[W];

endmodule

>>> hw/rtl/raid5_sector_to_disk_mapper.sv
// raid5 rotating parity address mapper
// command channel: a beat is taken at each rising edge with start high and
// busy low; busy is always low, so one sector number can enter every cycle.
// result channel: done is high for one cycle with data_column,
// parity_column and disk_sector; results come out in order of entry.
// the datapath is three rows of one-bit restoring divider cells (sector
// by unit size, unit by data columns and by columns in parallel, stripe by
// columns), then registers for the split stripe times unit-size product
// and for the final add.
// throughput is one beat per cycle, set by the cells handing a beat onward
// every cycle.
// configuration: cfg_we writes cfg_data into the register at cfg_index in
// the same edge; write only while no beat is in flight.
// reset clears the cell valid bits and loads 3 columns and 32 sectors per
// unit. the receiver cannot stall, so results are never held.
`include "raid5_sector_to_disk_mapper_macros.svh"

module raid5_sector_to_disk_mapper #(
    parameter int MAX_COLUMNS  = r5m_pkg::DEF_MAX_COLUMNS,
    parameter int ADDRESS_BITS = r5m_pkg::DEF_ADDRESS_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  r5m_pkg::cfg_index_t       cfg_index,
    input  r5m_pkg::cfg_data_t        cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [ADDRESS_BITS-1:0]   array_sector,
    output logic                      done,
    output logic [4:0]                data_column,
    output logic [4:0]                parity_column,
    output logic [ADDRESS_BITS-1:0]   disk_sector
);
    import r5m_pkg::*;

    localparam int A  = ADDRESS_BITS;
    localparam int CB = $clog2(MAX_COLUMNS + 1);
    localparam int LO = A / 2;
    localparam int HI = A - LO;

    logic [5:0]  ncol_reg;
    logic [15:0] spu_reg;
    logic [CB-1:0] cols_eff;
    logic [CB-1:0] dcols_eff;
    logic [15:0]   spu_eff;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncol_reg <= RST_NUM_COLUMNS;
            spu_reg  <= RST_SECTORS_PER_UNIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_COLUMNS:      ncol_reg <= cfg_data[5:0];
                REG_SECTORS_PER_UNIT: spu_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // clamped settings; the user must keep them stable while beats are in flight, the block does not enforce it
    always_comb
    begin
        if (32'(ncol_reg) < 32'd2)
            cols_eff = CB'(2);
        else if (32'(ncol_reg) > 32'(MAX_COLUMNS))
            cols_eff = CB'(MAX_COLUMNS);
        else
            cols_eff = CB'(ncol_reg);
        dcols_eff = cols_eff - CB'(1);
        spu_eff   = (spu_reg == 16'd0) ? 16'd1 : spu_reg;
    end

    assign busy = 1'b0;

    beat_ctl_t ctl_in;
    assign ctl_in.vld = start & ~busy;

    // sector / unit size
    beat_ctl_t   ctl1;
    logic [A-1:0] unit1;
    logic [15:0]  off1;

    r5m_div_chain #(.W(A), .DW(16), .SW(1)) u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_in),
        .dividend  (array_sector),
        .side_in   (1'b0),
        .divisor   (spu_eff),
        .ctl_out   (ctl1),
        .quotient  (unit1),
        .remainder (off1),
        .side_out  ()
    );

    // unit / data columns gives the stripe
    beat_ctl_t    ctl2;
    logic [A-1:0] stripe2;
    logic [15:0]  off2;

    r5m_div_chain #(.W(A), .DW(CB), .SW(16)) u_stripe (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl1),
        .dividend  (unit1),
        .side_in   (off1),
        .divisor   (dcols_eff),
        .ctl_out   (ctl2),
        .quotient  (stripe2),
        .remainder (),
        .side_out  (off2)
    );

    // unit mod columns gives the data column, in step with the stripe row
    beat_ctl_t     ctl2b;
    logic [CB-1:0] dcol2;

    r5m_div_chain #(.W(A), .DW(CB), .SW(1)) u_dcol (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl1),
        .dividend  (unit1),
        .side_in   (1'b0),
        .divisor   (cols_eff),
        .ctl_out   (ctl2b),
        .quotient  (),
        .remainder (dcol2),
        .side_out  ()
    );

    // stripe mod columns for the parity rotation
    localparam int SW3 = A + 16 + CB;
    beat_ctl_t      ctl3;
    logic [CB-1:0]  prot3;
    logic [SW3-1:0] side3;
    logic [A-1:0]   stripe3;
    logic [15:0]    off3;
    logic [CB-1:0]  dcol3;

    r5m_div_chain #(.W(A), .DW(CB), .SW(SW3)) u_prot (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl2),
        .dividend  (stripe2),
        .side_in   ({stripe2, off2, dcol2}),
        .divisor   (cols_eff),
        .ctl_out   (ctl3),
        .quotient  (),
        .remainder (prot3),
        .side_out  (side3)
    );

    assign {stripe3, off3, dcol3} = side3;

    // split product of stripe and unit size
    logic            vld_m1_reg;
    logic [LO+15:0]  plo_reg;
    logic [HI+15:0]  phi_reg;
    logic [15:0]     off_m1_reg;
    logic [CB-1:0]   dcol_m1_reg;
    logic [CB-1:0]   pcol_m1_reg;

    always_ff @(posedge clk)
    begin
        plo_reg     <= stripe3[LO-1:0] * spu_eff;
        phi_reg     <= stripe3[A-1:LO] * spu_eff;
        off_m1_reg  <= off3;
        dcol_m1_reg <= dcol3;
        pcol_m1_reg <= dcols_eff - prot3;
    end

    // final add
    logic            vld_m2_reg;
    logic [A-1:0]    dsec_reg;
    logic [4:0]      dcol_reg;
    logic [4:0]      pcol_reg;
    logic [A+15:0]   sum;

    always_comb
    begin
        sum = {phi_reg, {LO{1'b0}}} + (A+16)'(plo_reg) + (A+16)'(off_m1_reg);
    end

    always_ff @(posedge clk)
    begin
        dsec_reg <= sum[A-1:0];
        dcol_reg <= 5'(dcol_m1_reg);
        pcol_reg <= 5'(pcol_m1_reg);
    end

    // output strobe pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m1_reg <= 1'b0;
            vld_m2_reg <= 1'b0;
        end
        else
        begin
            vld_m1_reg <= ctl3.vld;
            vld_m2_reg <= vld_m1_reg;
        end
    end

    assign done          = vld_m2_reg;
    assign data_column   = dcol_reg;
    assign parity_column = pcol_reg;
    assign disk_sector   = dsec_reg;

    // checks
    `R5M_ASSERT_EQ(a_rows_lockstep, clk, rst_n, ctl2.vld, ctl2b.vld)
    `R5M_ASSERT_IMPL(a_dcol_range, clk, rst_n, ctl2b.vld, dcol2 < cols_eff)
    `R5M_ASSERT_IMPL(a_pcol_range, clk, rst_n, vld_m1_reg, pcol_m1_reg <= dcols_eff)

endmodule
